/* rtl/swa_pkg.sv */
// Shared constants and types for the sliding window aggregator.
// No dependencies; imported by every module of the block.
package swa_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned UsedW        = 9;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 9;
  localparam int unsigned DefaultDepth = 256;
  localparam int unsigned ResetLength  = 256;

  typedef enum logic [1:0] {
    AGG_AVG = 2'd0,
    AGG_MAX = 2'd1,
    AGG_MIN = 2'd2,
    AGG_SUM = 2'd3
  } agg_mode_e;

  localparam logic [CfgIdxW-1:0] RegAggMode      = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegWindowLength = CfgIdxW'(1);

endpackage

/* rtl/sliding_window_aggregate.sv */
// Sliding window aggregator, top level. Builds on swa_pkg, swa_window_mem and swa_divider.
// One item at a time: on accept the block reports sum, minimum, maximum or average of the
// samples held so far, then stores the new sample over the oldest once the window is full.
// Unless the window is empty, the block scans the n stored samples (n up to WindowDepth)
// through the single read port of the sample memory, one entry per cycle; the average
// then also runs the bit-serial divider. An empty window skips both the scan and the
// divider in every mode.
// in_stall_o is low only between items; a finished result waits in an
// output register, so the next item is taken while it is still unread. Writing
// window_length empties the window; cfg_ready_o is always high.
module sliding_window_aggregate import swa_pkg::*; #(
  parameter int unsigned WindowDepth = DefaultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  aggregate_o,
  output logic [8:0]          samples_used_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned CntW  = $clog2(WindowDepth + 1);
  localparam int unsigned AddrW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int unsigned LenW  = (CntW > CfgDataW) ? CntW : CfgDataW;
  localparam int unsigned ResetLen = (ResetLength > WindowDepth) ? WindowDepth : ResetLength;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StScan   = 3'd1;
  localparam logic [2:0] StDrain  = 3'd2;
  localparam logic [2:0] StDivGo  = 3'd3;
  localparam logic [2:0] StDivW   = 3'd4;
  localparam logic [2:0] StFinish = 3'd5;

  logic [2:0]       state_q;
  agg_mode_e        mode_q;
  logic [CntW-1:0]  eff_len_q;
  logic [CntW-1:0]  filled_q;
  logic [AddrW-1:0] oldest_q;
  logic [CntW-1:0]  n_q;
  logic [CntW-1:0]  rd_idx_q;
  logic             rvalid_q;
  logic             first_q;
  logic [DataW-1:0] sample_q;
  logic [DataW-1:0] acc_q;
  logic [DataW-1:0] acc_d;
  logic [DataW-1:0] res_q;
  logic             neg_q;
  logic             out_valid_q;
  logic [DataW-1:0] agg_q;
  logic [UsedW-1:0] used_q;

  logic             in_xfer;
  logic             cfg_xfer;
  logic             out_free;
  logic             finish;
  logic             full;
  logic [CntW-1:0]  rd_idx_inc;
  logic [CntW-1:0]  oldest_inc;
  logic [LenW-1:0]  len_ext;
  logic [CntW-1:0]  len_d;
  logic [AddrW-1:0] wr_addr;
  logic [DataW-1:0] rd_data;
  logic [DataW-1:0] magnitude;
  logic             div_start;
  logic             div_done;
  logic [DataW-1:0] quotient;

  assign in_stall_o  = (state_q != StIdle);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign finish      = (state_q == StFinish) && out_free;
  assign full        = (filled_q == eff_len_q);
  assign rd_idx_inc  = rd_idx_q + CntW'(1);
  assign oldest_inc  = CntW'(oldest_q) + CntW'(1);
  assign wr_addr     = full ? oldest_q : filled_q[AddrW-1:0];
  assign magnitude   = acc_q[DataW-1] ? (~acc_q + DataW'(1)) : acc_q;
  assign div_start   = (state_q == StDivGo);

  always_comb begin
    len_ext = LenW'(cfg_wdata_i);
    if (len_ext == '0) begin
      len_d = CntW'(1);
    end else if (len_ext > LenW'(WindowDepth)) begin
      len_d = CntW'(WindowDepth);
    end else begin
      len_d = CntW'(len_ext);
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (first_q) begin
      acc_d = rd_data;
    end else begin
      case (mode_q)
        AGG_MAX: if ($signed(rd_data) > $signed(acc_q)) acc_d = rd_data;
        AGG_MIN: if ($signed(rd_data) < $signed(acc_q)) acc_d = rd_data;
        default: acc_d = acc_q + rd_data;
      endcase
    end
  end

  swa_window_mem #(
    .Depth (WindowDepth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (finish),
    .wr_addr_i (wr_addr),
    .wr_data_i (sample_q),
    .rd_en_i   (state_q == StScan),
    .rd_addr_i (rd_idx_q[AddrW-1:0]),
    .rd_data_o (rd_data)
  );

  swa_divider #(
    .DivW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (magnitude),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mode_q      <= AGG_AVG;
      eff_len_q   <= CntW'(ResetLen);
      filled_q    <= '0;
      oldest_q    <= '0;
      rvalid_q    <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rvalid_q <= (state_q == StScan);
      if (rvalid_q) begin
        first_q <= 1'b0;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_xfer) begin
            first_q <= 1'b1;
            state_q <= (filled_q == '0) ? StFinish : StScan;
          end
        end
        StScan: begin
          if (rd_idx_inc == n_q) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          state_q <= (mode_q == AGG_AVG) ? StDivGo : StFinish;
        end
        StDivGo: begin
          state_q <= StDivW;
        end
        StDivW: begin
          if (div_done) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
            if (full) begin
              oldest_q <= (oldest_inc == eff_len_q) ? '0 : oldest_inc[AddrW-1:0];
            end else begin
              filled_q <= filled_q + CntW'(1);
            end
          end
        end
        default: state_q <= StIdle;
      endcase
      if (cfg_xfer) begin
        case (cfg_index_i)
          RegAggMode: mode_q <= agg_mode_e'(cfg_wdata_i[1:0]);
          RegWindowLength: begin
            eff_len_q <= len_d;
            filled_q  <= '0;
            oldest_q  <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sample_q <= sample_i;
      n_q      <= filled_q;
      rd_idx_q <= '0;
      res_q    <= '0;
    end
    if (state_q == StScan) begin
      rd_idx_q <= rd_idx_inc;
    end
    if (rvalid_q) begin
      acc_q <= acc_d;
    end
    if (state_q == StDrain) begin
      res_q <= acc_d;
    end
    if (div_start) begin
      neg_q <= acc_q[DataW-1];
    end
    if ((state_q == StDivW) && div_done) begin
      res_q <= neg_q ? (~quotient + DataW'(1)) : quotient;
    end
    if (finish) begin
      agg_q  <= res_q;
      used_q <= UsedW'(n_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign aggregate_o    = agg_q;
  assign samples_used_o = used_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= eff_len_q)
    else $error("window fill count beyond window length");

  a_oldest_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oldest_q != '0) |-> full)
    else $error("oldest pointer moved before window filled");

  a_rvalid_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> (state_q == StScan || state_q == StDrain))
    else $error("read data returned outside scan");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDivW))
    else $error("divider finished while not awaited");

  a_result_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StFinish))
    else $error("result presented without finishing an item");

endmodule

/* rtl/swa_window_mem.sv */
// Sample store of the aggregator: one write port, one read port,
// registered read data. Uses swa_pkg for the data width.
module swa_window_mem import swa_pkg::*; #(
  parameter int unsigned Depth = DefaultDepth,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/swa_divider.sv */
// Restoring divider for the average: one quotient bit per cycle.
// Unsigned 32-bit dividend by a count; uses swa_pkg for widths.
module swa_divider import swa_pkg::*; #(
  parameter int unsigned DivW = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DivW-1:0]  divisor_i,
  output logic             done_o,
  output logic [DataW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DataW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] rem_q;
  logic [DataW-1:0] quo_q;
  logic [DivW-1:0] dsr_q;

  logic [DivW:0]   shifted;
  logic [DivW:0]   diff;
  logic            ge;

  assign shifted = {rem_q, quo_q[DataW-1]};
  assign ge      = shifted >= {1'b0, dsr_q};
  assign diff    = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DataW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DivW-1:0] : shifted[DivW-1:0];
      quo_q <= {quo_q[DataW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* test/tb_sliding_window_aggregate.sv */
`timescale 1ns / 100ps
// Self-checking bench for sliding_window_aggregate: random and directed samples, all modes.
// Depends on swa_pkg and the block's RTL; predicts each aggregate and checks it on transfer.
module tb_sliding_window_aggregate;
  import swa_pkg::*;

  localparam int unsigned WindowDepth = DefaultDepth;
  localparam int TotalItems  = 800;
  localparam int HoldCycles  = 800;
  localparam int DrainCycles = 320;
  localparam int CycleLimit  = 2_000_000;
  localparam int PrintCap    = 40;
  localparam logic [CfgIdxW-1:0] RegUnused0 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegUnused1 = CfgIdxW'(3);

  typedef struct packed {
    logic signed [31:0] agg;
    logic [8:0]         used;
  } window_result_t;

  logic                clk_i;
  logic                rst_n      = 1'b0;
  logic                drv_valid  = 1'b0;
  logic signed [31:0]  drv_sample = '0;
  logic                out_stall  = 1'b0;
  logic                cfg_valid  = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_wdata  = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic signed [31:0]  aggregate_o;
  logic [8:0]          samples_used_o;
  logic                cfg_ready_o;

  // predictor state
  logic [31:0]   win_mem [WindowDepth];
  int unsigned   win_head = 0;
  int unsigned   win_fill = 0;
  agg_mode_e     cur_mode = AGG_AVG;
  logic [8:0]    cur_len  = 9'(ResetLength);

  window_result_t     owed_aggregates [$];
  logic signed [31:0] sample_backlog [$];

  int n_queued  = 0;
  int n_sent    = 0;
  int n_got     = 0;
  int n_writes  = 0;
  int n_errors  = 0;
  int cycles    = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int mode_hits [4] = '{default: 0};

  sliding_window_aggregate u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (drv_valid),
    .in_stall_o     (in_stall_o),
    .sample_i       (drv_sample),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .aggregate_o    (aggregate_o),
    .samples_used_o (samples_used_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= PrintCap) $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // Aggregate over the held samples, then store the new one over the oldest when full.
  task automatic aggregate_and_store(input logic signed [31:0] s);
    int unsigned    n;
    int unsigned    span_len;
    int unsigned    i;
    logic [31:0]    acc;
    window_result_t r;
    n = win_fill;
    acc = '0;
    if (n != 0) begin
      case (cur_mode)
        AGG_MAX, AGG_MIN: begin
          acc = win_mem[0];
          for (i = 1; i < n; i++) begin
            if ((cur_mode == AGG_MAX) ? ($signed(win_mem[i]) > $signed(acc))
                                      : ($signed(win_mem[i]) < $signed(acc)))
              acc = win_mem[i];
          end
        end
        default: begin
          for (i = 0; i < n; i++) acc += win_mem[i];
          if (cur_mode == AGG_AVG) acc = 32'(longint'($signed(acc)) / longint'(n));
        end
      endcase
    end
    r.agg  = acc;
    r.used = 9'(n);
    owed_aggregates.push_back(r);
    mode_hits[cur_mode]++;

    span_len = (cur_len == 0) ? 1 : ((cur_len > WindowDepth) ? WindowDepth : cur_len);
    win_mem[(win_head + win_fill) % span_len] = s;
    if (win_fill == span_len) win_head = (win_head + 1) % span_len;
    else win_fill++;
  endtask

  // Called from a falling edge; returns on the falling edge after the transfer.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    n_writes++;
    case (idx)
      RegAggMode: cur_mode = agg_mode_e'(val[1:0]);
      RegWindowLength: begin
        cur_len  = val;
        win_head = 0;
        win_fill = 0;
      end
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (sample_backlog.size() != 0 || drv_valid || owed_aggregates.size() != 0 ||
           in_stall_o);
  endtask

  task automatic queue_sample(input logic signed [31:0] s);
    sample_backlog.push_back(s);
    n_queued++;
  endtask

  function automatic logic signed [31:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      case ($urandom_range(3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return 32'sh0000_0000;
        default: return 32'shFFFF_FFFF;
      endcase
    end
    if (pick < 30) begin
      if ($urandom_range(1) != 0) return 32'h7FFF_FFFF - $urandom_range(255);
      return 32'h8000_0000 + $urandom_range(255);
    end
    if (pick < 55) return 32'(int'($urandom_range(200)) - 100);
    return $urandom;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      drv_valid  <= 1'b0;
      drv_sample <= '0;
    end else begin
      if (drv_valid && !in_stall_o) begin
        aggregate_and_store(drv_sample);
        n_sent++;
      end
      if (!drv_valid || !in_stall_o) begin
        if (sample_backlog.size() != 0 &&
            $urandom_range(99) >= ((n_sent < 270) ? 36 : (n_sent < 540) ? 67 : 0)) begin
          drv_valid  <= 1'b1;
          drv_sample <= sample_backlog.pop_front();
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_n) begin
    window_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        n_got++;
        if (owed_aggregates.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d used %0d",
                                    aggregate_o, samples_used_o));
        end else begin
          want = owed_aggregates.pop_front();
          if (aggregate_o !== want.agg)
            report_mismatch($sformatf("result %0d: aggregate %0d, predicted %0d",
                                      n_got, aggregate_o, want.agg));
          if (samples_used_o !== want.used)
            report_mismatch($sformatf("result %0d: samples_used %0d, predicted %0d",
                                      n_got, samples_used_o, want.used));
        end
      end
      // one long hold-off while the sender keeps offering, so the block backs up
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_got >= 50 && n_queued - n_got > 30) begin
        out_stall <= 1'b1;
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < ((n_got < 270) ? 67 : (n_got < 540) ? 36 : 0));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout: %0d samples sent, %0d results seen", n_sent, n_got);
      $display("tb_sliding_window_aggregate: errors");
      $finish;
    end
  end

  initial begin
    int             phase;
    int             batch;
    int unsigned    pick;
    logic [8:0]     len_w;
    window_result_t left;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;

    // reset settings: average over up to 256, wrapping sums
    wait_idle();
    queue_sample(32'sh7FFF_FFFF);
    queue_sample(32'sh7FFF_FFFF);
    queue_sample(32'sh0000_0001);
    queue_sample(32'sh8000_0000);
    queue_sample(32'shFFFF_FFFF);

    // mode change keeps the window
    wait_idle();
    write_reg(RegAggMode, 9'(AGG_MAX));
    queue_sample(32'sh0000_0000);
    queue_sample(32'sh8000_0000);

    // upper data bits of the mode are dropped; spare indexes do nothing
    wait_idle();
    write_reg(RegAggMode, {7'h7F, AGG_MIN});
    write_reg(RegUnused0, 9'h1FF);
    write_reg(RegUnused1, 9'h000);
    queue_sample(32'sh0000_0005);
    queue_sample(32'sh0000_0006);

    wait_idle();
    write_reg(RegAggMode, 9'(AGG_SUM));
    queue_sample(32'sh0000_0001);
    queue_sample(32'sh0000_0002);

    // zero length behaves as one
    wait_idle();
    write_reg(RegWindowLength, 9'd0);
    queue_sample(32'sd10);
    queue_sample(32'sd20);
    queue_sample(32'sd30);

    // oversized length saturates; negative average truncates toward zero
    wait_idle();
    write_reg(RegAggMode, 9'(AGG_AVG));
    write_reg(RegWindowLength, 9'h1FF);
    queue_sample(-32'sd7);
    queue_sample(-32'sd2);
    queue_sample(32'sd3);

    wait_idle();
    write_reg(RegAggMode, 9'(AGG_MAX));
    write_reg(RegWindowLength, 9'd2);
    queue_sample(32'sh8000_0000);
    queue_sample(32'sh8000_0000);
    queue_sample(32'sh7FFF_FFFF);
    queue_sample(32'sh0000_0001);

    // random phases; the first fills and wraps the full-depth window
    phase = 0;
    while (n_queued < TotalItems) begin
      wait_idle();
      write_reg(RegAggMode, 9'($urandom));
      pick = $urandom_range(99);
      if (phase == 0) begin
        write_reg(RegWindowLength, 9'(WindowDepth));
        batch = 280;
      end else if (pick < 20) begin
        batch = $urandom_range(40, 10);
      end else if (pick < 26) begin
        write_reg(RegWindowLength, 9'd0);
        batch = $urandom_range(15, 5);
      end else if (pick < 32) begin
        write_reg(RegWindowLength, 9'($urandom_range(511, WindowDepth + 1)));
        batch = $urandom_range(30, 10);
      end else if (pick < 38) begin
        write_reg(RegWindowLength, 9'($urandom_range(WindowDepth, WindowDepth - 1)));
        batch = $urandom_range(30, 10);
      end else begin
        if (pick < 44)
          write_reg(($urandom_range(1) != 0) ? RegUnused0 : RegUnused1, 9'($urandom));
        len_w = 9'($urandom_range(24, 1));
        write_reg(RegWindowLength, len_w);
        batch = $urandom_range(60, 10);
      end
      repeat (batch) queue_sample(rand_sample());
      phase++;
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    while (owed_aggregates.size() != 0) begin
      left = owed_aggregates.pop_front();
      report_mismatch($sformatf("missing result %0d used %0d", left.agg, left.used));
    end
    $display("Run covered %0d samples over %0d phases with %0d register transfers.",
             n_sent, phase, n_writes);
    $display("Results by mode: avg %0d, max %0d, min %0d, sum %0d; %0d mismatches.",
             mode_hits[AGG_AVG], mode_hits[AGG_MAX], mode_hits[AGG_MIN],
             mode_hits[AGG_SUM], n_errors);
    if (n_errors == 0) begin
      $display("tb_sliding_window_aggregate: clean");
    end else begin
      $display("tb_sliding_window_aggregate: errors");
    end
    $finish;
  end

endmodule
